>>> rtl/core/size_class_pool_allocator_defines.svh
// ----------------------------------------------------------------------------
// Size-class pool allocator assertion macros
// Implication checks on the local clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_POOL_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SCPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCPA_ASSERT_IMP(lbl, ante, cons, msg)
`define SCPA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared types, codes and constants of the size-class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

	localparam int unsigned NUM_BINS = 8;
	localparam int unsigned BIN_W    = 3;
	localparam int unsigned BS_W     = 7;   // block size up to 64
	localparam int unsigned ALIGN_W  = 24;  // lowest set bit of a 24-bit value
	localparam logic [15:0] MAX_POOL_SIZE = 16'd64;
	localparam logic [31:0] LOW24_MASK    = 32'h00FF_FFFF;
	localparam int unsigned BIN_SHIFT     = 3;

	localparam logic [1:0] REG_BASE    = 2'd0;
	localparam logic [1:0] REG_CNT_LOW = 2'd1;
	localparam logic [1:0] REG_CNT_HIGH = 2'd2;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_FIND  = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_FAIL = 2'd1,
		STS_DUP  = 2'd2
	} status_code_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] request_size;
		logic [15:0] required_alignment;
		logic [31:0] block_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_address;
		logic [2:0]  owner_bin;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INIT_BIN,
		ST_INIT_FILL,
		ST_ALLOC_PICK,
		ST_ALLOC_RD,
		ST_ALLOC_MUL,
		ST_ALLOC_ADD,
		ST_OWN,
		ST_OWN_CHK,
		ST_DIV,
		ST_FREE_WR,
		ST_RESULT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic init_start;
		logic init_bin;
		logic fill_wr;
		logic init_next;
		logic init_finish;
		logic pick;
		logic alloc_rd;
		logic alloc_mul;
		logic alloc_add;
		logic own;
		logic div_start;
		logic div_step;
		logic free_wr;
		logic res_fail;
		logic res_dup;
		logic res_find;
		logic load_out;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_code_t cmd;
		logic      size_ok;
		logic      inited;
		logic      fill_done;
		logic      last_bin;
		logic      found;
		logic      owned;
		logic      can_free;
		logic      div_done;
	} stat_t;

	// pools are laid out in this bin order from the base address
	function automatic logic [BIN_W-1:0] layout_bin(input logic [BIN_W-1:0] k);
		logic [BIN_W-1:0] b;
		case (k)
			3'd0:    b = 3'd7;
			3'd1:    b = 3'd3;
			3'd2:    b = 3'd5;
			3'd3:    b = 3'd1;
			3'd4:    b = 3'd0;
			3'd5:    b = 3'd2;
			3'd6:    b = 3'd4;
			3'd7:    b = 3'd6;
			default: b = 3'd0;
		endcase
		return b;
	endfunction

	function automatic logic [BS_W-1:0] block_size(input logic [BIN_W-1:0] bin);
		logic [3:0] m;
		m = {1'b0, bin} + 4'd1;
		return {m, 3'b000};
	endfunction

endpackage

>>> rtl/core/scpa_dp.sv
// ----------------------------------------------------------------------------
// scpa_dp
// Allocator datapath: config registers, pool tables, free-stack memory,
// bin pick, owner lookup, reciprocal divide and the response register.
// ----------------------------------------------------------------------------
module scpa_dp import scpa_pkg::*; #(
	parameter int unsigned MAX_BLOCKS_PER_BIN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  req_t        req,
	output rsp_t        rsp,
	input  ctl_t        ctl,
	output stat_t       stat
);

	localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS_PER_BIN + 1);
	localparam int unsigned IDX_W  = (MAX_BLOCKS_PER_BIN > 1) ? $clog2(MAX_BLOCKS_PER_BIN) : 1;
	localparam int unsigned SPAN_W = CNT_W + 6;
	localparam int unsigned DV_W   = SPAN_W - BIN_SHIFT;
	localparam int unsigned QP_W   = DV_W + 25;
	localparam int unsigned MEM_D  = NUM_BINS * MAX_BLOCKS_PER_BIN;
	localparam int unsigned ADDR_W = $clog2(MEM_D);

	logic [31:0] base_q;
	logic [63:0] cnt_lo_q, cnt_hi_q;
	req_t        req_q;

	logic [CNT_W-1:0]   tops_q   [NUM_BINS];
	logic [CNT_W-1:0]   counts_q [NUM_BINS];
	logic [31:0]        starts_q [NUM_BINS];
	logic [ALIGN_W-1:0] aligns_q [NUM_BINS];
	logic [SPAN_W-1:0]  spans_q  [NUM_BINS];
	logic [31:0]        rstart_q, rend_q;
	logic               inited_q;

	logic [BIN_W-1:0]  k_q;
	logic [31:0]       cursor_q;
	logic [CNT_W-1:0]  fill_i_q;
	logic [BIN_W-1:0]  pick_bin_q, own_bin_q;
	logic              found_q, owned_q;
	logic [SPAN_W-1:0] off_q, prod_q;
	logic [IDX_W-1:0]  rd_q;
	logic [DV_W-1:0]   quo_q;
	logic              div_done_q;
	rsp_t              res_q, rsp_q;

	logic [IDX_W-1:0] mem [MEM_D];

	// init step
	logic [BIN_W-1:0]   cur_b;
	logic [63:0]        cnt_word;
	logic [15:0]        raw_cnt;
	logic [CNT_W-1:0]   n_cl;
	logic [BS_W-1:0]    bs_cur;
	logic [SPAN_W-1:0]  span_cur;
	logic [31:0]        comb_w, align_w;

	always_comb begin
		cur_b    = layout_bin(k_q);
		cnt_word = cur_b[2] ? cnt_hi_q : cnt_lo_q;
		raw_cnt  = cnt_word[{cur_b[1:0], 4'b0000} +: 16];
		n_cl     = (raw_cnt > 16'(MAX_BLOCKS_PER_BIN)) ? CNT_W'(MAX_BLOCKS_PER_BIN)
		                                              : CNT_W'(raw_cnt);
		bs_cur   = block_size(cur_b);
		span_cur = SPAN_W'(n_cl) * SPAN_W'(bs_cur);
		comb_w   = 32'(bs_cur) | (cursor_q & LOW24_MASK);
		align_w  = comb_w & (~comb_w + 32'd1);
	end

	// allocate pick: lowest eligible bin at or above the size class
	logic [15:0]         sz_m1;
	logic [BIN_W-1:0]    b0;
	logic [NUM_BINS-1:0] ahit;
	logic [BIN_W-1:0]    apick;

	always_comb begin
		sz_m1 = req_q.request_size - 16'd1;
		b0    = sz_m1[BIN_SHIFT +: BIN_W];
		apick = '0;
		for (int b = 0; b < NUM_BINS; b++) begin
			ahit[b] = (BIN_W'(b) >= b0)
			       && (ALIGN_W'(req_q.required_alignment) <= aligns_q[b])
			       && (tops_q[b] != '0);
		end
		for (int b = NUM_BINS - 1; b >= 0; b--) begin
			if (ahit[b]) apick = BIN_W'(b);
		end
	end

	// owner lookup
	logic [31:0]         off_all [NUM_BINS];
	logic [NUM_BINS-1:0] ohit;
	logic [BIN_W-1:0]    opick;
	logic                in_region;

	always_comb begin
		in_region = inited_q && (req_q.block_address >= rstart_q)
		         && (req_q.block_address < rend_q);
		opick = '0;
		for (int b = 0; b < NUM_BINS; b++) begin
			off_all[b] = req_q.block_address - starts_q[b];
			ohit[b]    = (counts_q[b] != '0) && (off_all[b] < 32'(spans_q[b]));
		end
		for (int b = NUM_BINS - 1; b >= 0; b--) begin
			if (ohit[b]) opick = BIN_W'(b);
		end
	end

	// divide by (bin + 1): multiply by ceil(2^24 / (bin + 1)), keep bits 24 and up;
	// exact for every quotient operand below 2^21
	function automatic logic [24:0] recip(input logic [BIN_W-1:0] b);
		logic [24:0] r;
		case (b)
			3'd0:    r = 25'd16777216;
			3'd1:    r = 25'd8388608;
			3'd2:    r = 25'd5592406;
			3'd3:    r = 25'd4194304;
			3'd4:    r = 25'd3355444;
			3'd5:    r = 25'd2796203;
			3'd6:    r = 25'd2396746;
			default: r = 25'd2097152;
		endcase
		return r;
	endfunction

	logic [QP_W-1:0] qprod;
	assign qprod = QP_W'(quo_q) * QP_W'(recip(own_bin_q));

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [BIN_W-1:0] b,
	                                              input logic [IDX_W-1:0] i);
		return ADDR_W'(b) * ADDR_W'(MAX_BLOCKS_PER_BIN) + ADDR_W'(i);
	endfunction

	logic [CNT_W-1:0]  top_m1;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [IDX_W-1:0]  mem_wdata;

	always_comb begin
		top_m1    = tops_q[pick_bin_q] - CNT_W'(1);
		mem_raddr = mem_addr(pick_bin_q, top_m1[IDX_W-1:0]);
		mem_we    = ctl.fill_wr || ctl.free_wr;
		if (ctl.fill_wr) begin
			mem_waddr = mem_addr(cur_b, fill_i_q[IDX_W-1:0]);
			mem_wdata = fill_i_q[IDX_W-1:0];
		end else begin
			mem_waddr = mem_addr(own_bin_q, tops_q[own_bin_q][IDX_W-1:0]);
			mem_wdata = quo_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (ctl.alloc_rd) rd_q <= mem[mem_raddr];
	end

	// config and pool tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			cnt_lo_q <= '0;
			cnt_hi_q <= '0;
			rstart_q <= '0;
			rend_q   <= '0;
			inited_q <= 1'b0;
			for (int b = 0; b < NUM_BINS; b++) begin
				tops_q[b]   <= '0;
				counts_q[b] <= '0;
				starts_q[b] <= '0;
				aligns_q[b] <= '0;
				spans_q[b]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE:     base_q   <= cfg_wdata[31:0];
					REG_CNT_LOW:  cnt_lo_q <= cfg_wdata;
					REG_CNT_HIGH: cnt_hi_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (ctl.init_start) rstart_q <= base_q;
			if (ctl.init_bin) begin
				starts_q[cur_b] <= cursor_q;
				aligns_q[cur_b] <= align_w[ALIGN_W-1:0];
				counts_q[cur_b] <= n_cl;
				spans_q[cur_b]  <= span_cur;
				tops_q[cur_b]   <= n_cl;
			end
			if (ctl.init_finish) begin
				rend_q   <= cursor_q;
				inited_q <= 1'b1;
			end
			if (ctl.alloc_rd) tops_q[pick_bin_q] <= top_m1;
			if (ctl.free_wr)  tops_q[own_bin_q]  <= tops_q[own_bin_q] + CNT_W'(1);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctl.latch) req_q <= req;
		if (ctl.init_start) begin
			k_q      <= '0;
			cursor_q <= base_q;
		end
		if (ctl.init_bin) begin
			cursor_q <= cursor_q + 32'(span_cur);
			fill_i_q <= '0;
		end
		if (ctl.fill_wr)   fill_i_q <= fill_i_q + CNT_W'(1);
		if (ctl.init_next) k_q <= k_q + BIN_W'(1);
		if (ctl.pick) begin
			pick_bin_q <= apick;
			found_q    <= |ahit;
		end
		if (ctl.alloc_mul) prod_q <= SPAN_W'(rd_q) * SPAN_W'(block_size(pick_bin_q));
		if (ctl.own) begin
			own_bin_q <= opick;
			owned_q   <= in_region && (|ohit);
			off_q     <= off_all[opick][SPAN_W-1:0];
		end
		if (ctl.div_start) begin
			quo_q      <= off_q[SPAN_W-1:BIN_SHIFT];
			div_done_q <= 1'b0;
		end
		if (ctl.div_step) begin
			quo_q      <= qprod[24 +: DV_W];
			div_done_q <= 1'b1;
		end
		if (ctl.res_fail || ctl.res_dup || ctl.init_finish) begin
			res_q.status         <= ctl.res_dup ? STS_DUP : (ctl.res_fail ? STS_FAIL : STS_OK);
			res_q.result_address <= '0;
			res_q.owner_bin      <= '0;
		end
		if (ctl.alloc_add) begin
			res_q.status         <= STS_OK;
			res_q.result_address <= starts_q[pick_bin_q] + 32'(prod_q);
			res_q.owner_bin      <= pick_bin_q;
		end
		if (ctl.res_find || ctl.free_wr) begin
			res_q.status         <= STS_OK;
			res_q.result_address <= '0;
			res_q.owner_bin      <= own_bin_q;
		end
		if (ctl.load_out) rsp_q <= res_q;
	end

	assign rsp = rsp_q;

	always_comb begin
		stat.cmd       = cmd_code_t'(req_q.command);
		stat.size_ok   = (req_q.request_size != '0) && (req_q.request_size <= MAX_POOL_SIZE);
		stat.inited    = inited_q;
		stat.fill_done = (fill_i_q == counts_q[cur_b]);
		stat.last_bin  = (k_q == BIN_W'(NUM_BINS - 1));
		stat.found     = found_q;
		stat.owned     = owned_q;
		stat.can_free  = (tops_q[own_bin_q] < counts_q[own_bin_q]);
		stat.div_done  = div_done_q;
	end

endmodule

>>> rtl/core/scpa_ctrl.sv
// ----------------------------------------------------------------------------
// scpa_ctrl
// Allocator sequencer: takes one request at a time, steps the datapath
// and hands the response to the output register.
// ----------------------------------------------------------------------------
`include "size_class_pool_allocator_defines.svh"

module scpa_ctrl import scpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	input  stat_t stat,
	output ctl_t  ctl
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (req_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				case (stat.cmd)
					CMD_INIT:  state_d = stat.inited ? ST_RESULT : ST_INIT_BIN;
					CMD_ALLOC: state_d = stat.size_ok ? ST_ALLOC_PICK : ST_RESULT;
					default:   state_d = ST_OWN;
				endcase
			end
			ST_INIT_BIN:   state_d = ST_INIT_FILL;
			ST_INIT_FILL: begin
				if (stat.fill_done) state_d = stat.last_bin ? ST_RESULT : ST_INIT_BIN;
			end
			ST_ALLOC_PICK: state_d = ST_ALLOC_RD;
			ST_ALLOC_RD:   state_d = stat.found ? ST_ALLOC_MUL : ST_RESULT;
			ST_ALLOC_MUL:  state_d = ST_ALLOC_ADD;
			ST_ALLOC_ADD:  state_d = ST_RESULT;
			ST_OWN:        state_d = ST_OWN_CHK;
			ST_OWN_CHK: begin
				if (!stat.owned || stat.cmd == CMD_FIND || !stat.can_free) state_d = ST_RESULT;
				else state_d = ST_DIV;
			end
			ST_DIV:        if (stat.div_done) state_d = ST_FREE_WR;
			ST_FREE_WR:    state_d = ST_RESULT;
			ST_RESULT:     if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE:   ctl.latch = req_valid;
			ST_DECODE: begin
				case (stat.cmd)
					CMD_INIT: begin
						ctl.res_dup    = stat.inited;
						ctl.init_start = !stat.inited;
					end
					CMD_ALLOC: ctl.res_fail = !stat.size_ok;
					default: ;
				endcase
			end
			ST_INIT_BIN:  ctl.init_bin = 1'b1;
			ST_INIT_FILL: begin
				ctl.fill_wr     = !stat.fill_done;
				ctl.init_finish = stat.fill_done && stat.last_bin;
				ctl.init_next   = stat.fill_done && !stat.last_bin;
			end
			ST_ALLOC_PICK: ctl.pick = 1'b1;
			ST_ALLOC_RD: begin
				ctl.alloc_rd = stat.found;
				ctl.res_fail = !stat.found;
			end
			ST_ALLOC_MUL: ctl.alloc_mul = 1'b1;
			ST_ALLOC_ADD: ctl.alloc_add = 1'b1;
			ST_OWN:       ctl.own = 1'b1;
			ST_OWN_CHK: begin
				if (!stat.owned) ctl.res_fail = 1'b1;
				else if (stat.cmd == CMD_FIND) ctl.res_find = 1'b1;
				else if (!stat.can_free) ctl.res_fail = 1'b1;
				else ctl.div_start = 1'b1;
			end
			ST_DIV:     ctl.div_step = !stat.div_done;
			ST_FREE_WR: ctl.free_wr = 1'b1;
			ST_RESULT:  ctl.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= ctl.load_out || (out_valid_q && rsp_stall);
		end
	end

	`SCPA_ASSERT_IMP(a_load_in_result, ctl.load_out, state_q == ST_RESULT, "response loaded outside result state")
	`SCPA_ASSERT_NXT(a_load_sets_valid, ctl.load_out, out_valid_q, "loaded response not presented")
	`SCPA_ASSERT_NXT(a_accept_decodes, state_q == ST_IDLE && req_valid, state_q == ST_DECODE, "accepted request not decoded")
	`SCPA_ASSERT_NXT(a_div_to_write, state_q == ST_DIV && stat.div_done, state_q == ST_FREE_WR, "divide done without stack write")

endmodule

>>> rtl/core/size_class_pool_allocator.sv
// ----------------------------------------------------------------------------
// size_class_pool_allocator
// Eight segregated free-list pools (8..64 byte blocks) with init, allocate,
// free and owner lookup.
// ----------------------------------------------------------------------------
// One request is processed at a time; the port stalls from acceptance until
// the response is in the output register, and a new request is taken while
// that response waits. Steps from acceptance to the load of the response:
// allocate runs decode, bin pick, stack read, block-size multiply, start add
// and load; free runs decode, owner lookup and check, one reciprocal multiply
// for the block index, stack write and load. A bad size or a repeated init
// loads after decode, no eligible bin after the stack read, and find, an
// unowned address or a full stack after the owner check. Init writes every
// block index of every pool into the free-stack memory one entry per cycle
// within each pool. The port takes the next request in the cycle after the
// load; a stalled output holds the result state until it is free.
// Config registers may only be written while the block is idle; init samples
// them. The free-stack memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module size_class_pool_allocator import scpa_pkg::*; #(
	parameter int unsigned MAX_BLOCKS_PER_BIN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	ctl_t  ctl;   // sequencer commands
	stat_t stat;  // datapath flags

	// sequencer: decode, init walk, alloc/free/find steps, response handoff
	scpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// pool tables, free-stack memory and arithmetic
	scpa_dp #(
		.MAX_BLOCKS_PER_BIN (MAX_BLOCKS_PER_BIN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: size-class pool allocator testbench
// Drives requests through the valid/stall port with random gaps and stalls,
// predicts every response from a local model of the eight free stacks and
// compares each response field by field, in order.
// ----------------------------------------------------------------------------
module tb_top import scpa_pkg::*; ();

	localparam int unsigned MAXB     = 1024;
	localparam logic [1:0]  REG_NONE = 2'd3;          // unused index, write ignored
	localparam logic [31:0] BASE0    = 32'h0001_2340; // 64-byte aligned
	// bin0 5, bin1 0 (empty pool), bin2 3, bin3 clamps to MAXB
	localparam logic [63:0] CNT_LO   = {16'hFFFF, 16'd3, 16'd0, 16'd5};
	localparam logic [63:0] CNT_HI   = {16'd3, 16'd6, 16'd2, 16'd4};
	localparam int          PHASE_N  = 470;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_wdata = '0;

	always #1 clk = ~clk;

	size_class_pool_allocator #(.MAX_BLOCKS_PER_BIN(MAXB)) u_dut (
		.clk, .arst_n, .req_valid, .req_stall, .req,
		.rsp_valid, .rsp_stall, .rsp, .cfg_we, .cfg_index, .cfg_wdata
	);

	// ---------------- allocator model ----------------
	logic [31:0] m_base;
	logic [63:0] m_cnt_lo, m_cnt_hi;
	logic [15:0] m_stack [NUM_BINS][MAXB];
	logic [31:0] m_top [NUM_BINS];
	logic [31:0] m_start [NUM_BINS];
	logic [31:0] m_align [NUM_BINS];
	logic [31:0] m_cnt [NUM_BINS];
	logic [31:0] m_rgn_lo, m_rgn_hi;
	logic        m_inited;

	typedef struct {
		logic [31:0] addr;
		logic [2:0]  bin;
	} live_blk_t;

	rsp_t      pending_rsp[$];  // expected responses, oldest first
	live_blk_t live_blocks[$];  // blocks handed out and not yet freed
	int        errors = 0;
	int        send_gap_pct = 0;
	int        rsp_stall_pct = 0;

	function automatic logic [31:0] bsize(input int b);
		return (b + 1) * 8;
	endfunction

	function automatic logic [31:0] clamped(input int b);
		logic [63:0] w;
		logic [31:0] c;
		w = (b < 4) ? m_cnt_lo : m_cnt_hi;
		c = 32'((w >> ((b % 4) * 16)) & 64'hFFFF);
		return (c > MAXB) ? MAXB : c;
	endfunction

	function automatic int owner(input logic [31:0] a);
		logic [31:0] off;
		if (!m_inited || a < m_rgn_lo || a >= m_rgn_hi)
			return -1;
		for (int b = 0; b < NUM_BINS; b++) begin
			off = a - m_start[b];
			if (m_cnt[b] != 0 && off < m_cnt[b] * bsize(b))
				return b;
		end
		return -1;
	endfunction

	task automatic model_reset();
		m_base = '0; m_cnt_lo = '0; m_cnt_hi = '0;
		m_rgn_lo = '0; m_rgn_hi = '0; m_inited = 1'b0;
		for (int b = 0; b < NUM_BINS; b++) begin
			m_top[b] = '0; m_start[b] = '0; m_align[b] = '0; m_cnt[b] = '0;
		end
	endtask

	// updates the model and returns the response this request should give
	function automatic rsp_t alloc_predict(input req_t r);
		rsp_t        o;
		logic [31:0] cur, comb, top, idx;
		int          b, ob;
		o = '{status: STS_FAIL, result_address: '0, owner_bin: '0};
		case (cmd_code_t'(r.command))
			CMD_INIT: begin
				if (m_inited) begin
					o.status = STS_DUP;
				end else begin
					cur = m_base;
					m_rgn_lo = m_base;
					for (int k = 0; k < NUM_BINS; k++) begin
						b = layout_bin(3'(k));
						comb = bsize(b) | (cur & LOW24_MASK);
						m_start[b] = cur;
						m_align[b] = comb & (32'd0 - comb);
						m_cnt[b] = clamped(b);
						for (int i = 0; i < m_cnt[b]; i++)
							m_stack[b][i] = 16'(i);
						m_top[b] = m_cnt[b];
						cur += m_cnt[b] * bsize(b);
					end
					m_rgn_hi = cur;
					m_inited = 1'b1;
					o.status = STS_OK;
				end
			end
			CMD_ALLOC: begin
				if (r.request_size != 0 && r.request_size <= MAX_POOL_SIZE) begin
					for (b = (r.request_size - 1) >> BIN_SHIFT; b < NUM_BINS; b++) begin
						if (r.required_alignment <= m_align[b] && m_top[b] != 0) begin
							top = m_top[b] - 1;
							if (top >= MAXB) top = MAXB - 1;
							idx = 32'(m_stack[b][top]);
							m_top[b] = top;
							o = '{status: STS_OK,
								result_address: m_start[b] + idx * bsize(b),
								owner_bin: 3'(b)};
							break;
						end
					end
				end
			end
			default: begin
				ob = owner(r.block_address);
				if (ob >= 0) begin
					if (r.command == CMD_FIND) begin
						o.status = STS_OK;
						o.owner_bin = 3'(ob);
					end else if (m_top[ob] < m_cnt[ob]) begin
						idx = (r.block_address - m_start[ob]) / bsize(ob);
						m_stack[ob][m_top[ob]] = 16'(idx);
						m_top[ob] += 1;
						o.status = STS_OK;
						o.owner_bin = 3'(ob);
					end
				end
			end
		endcase
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// ---------------- response side ----------------
	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report("response with none pending", rsp.result_address, '0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report("status", 32'(rsp.status), 32'(want.status));
				if (rsp.result_address !== want.result_address)
					report("result_address", rsp.result_address, want.result_address);
				if (rsp.owner_bin !== want.owner_bin)
					report("owner_bin", 32'(rsp.owner_bin), 32'(want.owner_bin));
			end
		end
	end

	// ---------------- request side ----------------
	// send one request; exp_given selects a typed expectation over the model
	task automatic send(input req_t r, input bit exp_given, input rsp_t exp_rsp);
		rsp_t p;
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		p = alloc_predict(r);
		if (r.command == CMD_ALLOC && p.status == STS_OK)
			live_blocks.push_back('{addr: p.result_address, bin: p.owner_bin});
		pending_rsp.push_back(exp_given ? exp_rsp : p);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk); // quiet spell before any register write
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [63:0] d);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BASE:     m_base = d[31:0];
			REG_CNT_LOW:  m_cnt_lo = d;
			REG_CNT_HIGH: m_cnt_hi = d;
			default:      ;
		endcase
	endtask

	function automatic logic [15:0] rand_align();
		int k;
		k = $urandom_range(99);
		if (k < 50) return 16'($urandom_range(8));
		if (k < 80) return 16'(1 << $urandom_range(15));
		return 16'($urandom);
	endfunction

	function automatic req_t rand_req();
		req_t      r;
		int        k, j;
		live_blk_t lb;
		r.command = CMD_ALLOC;
		r.request_size = 16'($urandom);
		r.required_alignment = rand_align();
		r.block_address = $urandom;
		k = $urandom_range(99);
		if (k < 3) begin
			r.command = CMD_INIT;
		end else if (k < 48) begin
			j = $urandom_range(99);
			if (j < 80) r.request_size = 16'($urandom_range(1, 64));
			else if (j < 90) r.request_size = 16'($urandom_range(65, 100)) & {16{j[0]}};
		end else begin
			r.command = (k < 83) ? CMD_FREE : CMD_FIND;
			j = $urandom_range(99);
			if (j < 70 && live_blocks.size() != 0) begin
				k = $urandom_range(live_blocks.size() - 1);
				lb = live_blocks[k];
				if (r.command == CMD_FREE) live_blocks.delete(k);
				r.block_address = lb.addr + $urandom_range(bsize(lb.bin) - 1);
			end else if (j < 85) begin
				r.block_address = m_rgn_lo - 8 + $urandom_range(m_rgn_hi - m_rgn_lo + 16);
			end
		end
		return r;
	endfunction

	// directed requests; typed expectations where they are plain
	typedef struct {
		req_t r;
		bit   given;
		rsp_t e;
	} dir_row_t;

	localparam rsp_t FAIL_R = '{status: STS_FAIL, result_address: '0, owner_bin: '0};
	localparam rsp_t OK_R   = '{status: STS_OK, result_address: '0, owner_bin: '0};
	localparam rsp_t DUP_R  = '{status: STS_DUP, result_address: '0, owner_bin: '0};

	dir_row_t dir_rows[] = '{
		// before init everything fails
		'{'{CMD_ALLOC, 16'd8, 16'd0, 32'h0}, 1, FAIL_R},
		'{'{CMD_FREE, 16'd0, 16'd0, BASE0}, 1, FAIL_R},
		'{'{CMD_FIND, 16'd0, 16'd0, BASE0}, 1, FAIL_R},
		'{'{CMD_INIT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1, OK_R},
		'{'{CMD_INIT, 16'd0, 16'd0, 32'h0}, 1, DUP_R},
		// bad sizes, edge sizes and alignment limits
		'{'{CMD_ALLOC, 16'd0, 16'd0, 32'h0}, 1, FAIL_R},
		'{'{CMD_ALLOC, 16'd65, 16'd0, 32'h0}, 1, FAIL_R},
		'{'{CMD_ALLOC, 16'hFFFF, 16'd0, 32'h0}, 1, FAIL_R},
		'{'{CMD_ALLOC, 16'd1, 16'd0, 32'h0}, 0, FAIL_R},
		'{'{CMD_ALLOC, 16'd64, 16'd0, 32'h0}, 0, FAIL_R},
		'{'{CMD_ALLOC, 16'd9, 16'd0, 32'h0}, 0, FAIL_R},   // bin 1 is empty
		'{'{CMD_ALLOC, 16'd8, 16'hFFFF, 32'h0}, 0, FAIL_R},
		'{'{CMD_ALLOC, 16'd8, 16'd64, 32'h0}, 0, FAIL_R},
		// lookups at the region edges and outside it
		'{'{CMD_FIND, 16'd0, 16'd0, BASE0}, 0, FAIL_R},
		'{'{CMD_FIND, 16'd0, 16'd0, BASE0 + 32'd7}, 0, FAIL_R},
		'{'{CMD_FIND, 16'd0, 16'd0, BASE0 - 32'd1}, 1, FAIL_R},
		'{'{CMD_FIND, 16'd0, 16'd0, 32'h0}, 1, FAIL_R},
		'{'{CMD_FIND, 16'd0, 16'd0, 32'hFFFF_FFFF}, 1, FAIL_R},
		// double free of a block still in the pool, then mid-block free
		'{'{CMD_FREE, 16'd0, 16'd0, BASE0 + 32'd3}, 0, FAIL_R},
		'{'{CMD_FREE, 16'd0, 16'd0, BASE0 + 32'd128 + 32'd5}, 0, FAIL_R},
		'{'{CMD_ALLOC, 16'd57, 16'd0, 32'h0}, 0, FAIL_R},
		'{'{CMD_FREE, 16'd0, 16'd0, BASE0 + 32'd128 + 32'd63}, 0, FAIL_R},
		'{'{CMD_FREE, 16'd0, 16'd0, 32'hFFFF_FFFF}, 1, FAIL_R}
	};

	initial begin
		model_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register extremes, then the layout that init will use
		cfg_write(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_write(REG_CNT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_write(REG_CNT_HIGH, 64'h0);
		cfg_write(REG_NONE, 64'h0);
		cfg_write(REG_BASE, {32'h0, BASE0});
		cfg_write(REG_CNT_LOW, CNT_LO);
		cfg_write(REG_CNT_HIGH, CNT_HI);

		foreach (dir_rows[i])
			send(dir_rows[i].r, dir_rows[i].given, dir_rows[i].e);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_gap_pct  = (ph == 0) ? 29 : (ph == 1) ? 61 : 0;
			rsp_stall_pct = (ph == 0) ? 61 : (ph == 1) ? 29 : 0;
			for (int n = 0; n < PHASE_N; n++) begin
				if (ph == 1 && n == PHASE_N / 2)
					drain(); // hold off until all responses are back
				send(rand_req(), 0, FAIL_R);
			end
			drain();
			// registers only matter at init; rewrite them anyway between phases
			cfg_write(REG_BASE, (ph == 0) ? 64'h0 : {32'h0, $urandom});
			cfg_write(REG_CNT_LOW, (ph == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
			cfg_write(REG_CNT_HIGH, {$urandom, $urandom});
			cfg_write(REG_NONE, {$urandom, $urandom});
		end

		if (errors == 0 && pending_rsp.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/scpa_pkg.sv
rtl/core/scpa_dp.sv
rtl/core/scpa_ctrl.sv
rtl/core/size_class_pool_allocator.sv
tb/tb_top.sv
